[rtl/pwam_pkg.sv]
// shared types and constants for the perspective warp address map
`default_nettype none
package pwam_pkg;
  localparam int CoefW = 32;
  localparam int CoordW = 11;
  localparam int SizeW = 12;
  localparam int AccW = 45;
  localparam int QW = 12;

  localparam logic [2:0] RegPairX = 3'd0;
  localparam logic [2:0] RegPairXy = 3'd1;
  localparam logic [2:0] RegPairY = 3'd2;
  localparam logic [2:0] RegPairW = 3'd3;
  localparam logic [2:0] RegWConst = 3'd4;
  localparam logic [2:0] RegSrcW = 3'd5;
  localparam logic [2:0] RegSrcH = 3'd6;

  typedef struct packed {
    logic signed [CoefW-1:0] xc, xr, x0, yc, yr, y0, wc, wr, w0;
    logic [SizeW-1:0] wlim, hlim;
  } cfg_t;
endpackage
`default_nettype wire

[rtl/pwam_regs.sv]
// apb register file holding the homography coefficients and source size
`default_nettype none
module pwam_regs #(
  parameter int MAX_IMAGE_DIM = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output pwam_pkg::cfg_t   cfg
);
  logic [63:0] px_r, pxy_r, py_r, pw_r;
  logic [31:0] w0_r;
  logic [11:0] sw_r, sh_r;
  logic [2:0] idx;
  logic wr;
  localparam logic [13:0] MaxDim = 14'(MAX_IMAGE_DIM);

  assign idx = paddr[5:3];
  assign wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= 64'h0010_0000_0000_0000;
      pxy_r <= '0;
      py_r <= 64'h0010_0000_0000_0000;
      pw_r <= '0;
      w0_r <= 32'h0010_0000;
      sw_r <= 12'd2048;
      sh_r <= 12'd2048;
    end else if (wr) begin
      case (idx)
        pwam_pkg::RegPairX: px_r <= pwdata;
        pwam_pkg::RegPairXy: pxy_r <= pwdata;
        pwam_pkg::RegPairY: py_r <= pwdata;
        pwam_pkg::RegPairW: pw_r <= pwdata;
        pwam_pkg::RegWConst: w0_r <= pwdata[31:0];
        pwam_pkg::RegSrcW: sw_r <= pwdata[11:0];
        pwam_pkg::RegSrcH: sh_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pwam_pkg::RegPairX: prdata = px_r;
      pwam_pkg::RegPairXy: prdata = pxy_r;
      pwam_pkg::RegPairY: prdata = py_r;
      pwam_pkg::RegPairW: prdata = pw_r;
      pwam_pkg::RegWConst: prdata = {32'd0, w0_r};
      pwam_pkg::RegSrcW: prdata = {52'd0, sw_r};
      pwam_pkg::RegSrcH: prdata = {52'd0, sh_r};
      default: prdata = '0;
    endcase
  end

  always_comb begin
    cfg.xc = px_r[63:32];  cfg.xr = px_r[31:0];
    cfg.x0 = pxy_r[63:32]; cfg.yc = pxy_r[31:0];
    cfg.yr = py_r[63:32];  cfg.y0 = py_r[31:0];
    cfg.wc = pw_r[63:32];  cfg.wr = pw_r[31:0];
    cfg.w0 = w0_r;
    // clamp to the largest supported image
    cfg.wlim = ({2'b00, sw_r} > MaxDim) ? MaxDim[11:0] : sw_r;
    cfg.hlim = ({2'b00, sh_r} > MaxDim) ? MaxDim[11:0] : sh_r;
  end
endmodule
`default_nettype wire

[rtl/pwam_div.sv]
// pipelined restoring divider, one quotient bit per stage, with range check
`default_nettype none
module pwam_div #(
  parameter int NW = 45,
  parameter int QB = 12
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [NW-1:0] den,
  output logic      [QB-1:0] quo,
  output logic               ovf
);
  // quotient is checked against 2^QB: ovf when num >= den << QB
  logic [NW-1:0] rem_r [QB+1];
  logic [NW-1:0] den_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          ovf_r [QB+1];
  logic [NW+QB-1:0] big;

  assign big = {{QB{1'b0}}, den} << QB;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0] <= '0;
      ovf_r[0] <= ({{QB{1'b0}}, num} >= big);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int B = QB - 1 - s;
    logic [NW+QB-1:0] sh;
    logic ge;
    assign sh = {{QB{1'b0}}, den_r[s]} << B;
    assign ge = ({{QB{1'b0}}, rem_r[s]} >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? NW'({{QB{1'b0}}, rem_r[s]} - sh) : rem_r[s];
        den_r[s+1] <= den_r[s];
        q_r[s+1] <= q_r[s] | (ge ? (QB'(1) << B) : '0);
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  end

  assign quo = q_r[QB];
  assign ovf = ovf_r[QB];
endmodule
`default_nettype wire

[rtl/pwam_dot.sv]
// one linear term c*col + r*row + k over two registered stages
`default_nettype none
module pwam_dot (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic signed [31:0] c,
  input  wire logic signed [31:0] r,
  input  wire logic signed [31:0] k,
  input  wire logic [10:0] col,
  input  wire logic [10:0] row,
  output logic signed [pwam_pkg::AccW-1:0] sum
);
  logic signed [43:0] pc_r, pr_r;
  logic signed [31:0] k_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pc_r <= c * $signed({1'b0, col});
      pr_r <= r * $signed({1'b0, row});
      k_r <= k;
      sum <= pwam_pkg::AccW'(pc_r) + pwam_pkg::AccW'(pr_r) + pwam_pkg::AccW'(k_r);
    end
  end
endmodule
`default_nettype wire

[rtl/perspective_warp_address_map_unit.sv]
// top level: registers, linear terms, dividers and output stage
// a request passes through the multiply/sum, sign, divide and output stages in turn;
// throughput: one request per cycle while the output is not stalled
// the whole pipeline advances when the output register is free or taken
// rst_n synchronous active low clears valid bits and loads reset coefficients
`default_nettype none
module perspective_warp_address_map_unit #(
  parameter int MAX_IMAGE_DIM = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [10:0] in_out_col,
  input  wire logic [10:0] in_out_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      out_src_x,
  output logic [10:0]      out_src_y,
  output logic             out_inside_res,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int AW = pwam_pkg::AccW;
  localparam int QB = pwam_pkg::QW;
  localparam int LAT = QB + 5;

  pwam_pkg::cfg_t cfg;
  logic en;
  logic [LAT-1:0] v_r;
  logic signed [AW-1:0] xs, ys, ws;
  logic [AW-1:0] ax_r, ay_r, aw_r;
  logic nx_r, ny_r, wz_r;
  logic [QB-1:0] qx, qy;
  logic ox, oy;
  logic [QB:0] nx_d, ny_d, wz_d;
  logic ins;

  pwam_regs #(.MAX_IMAGE_DIM(MAX_IMAGE_DIM)) u_regs (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .cfg
  );

  assign en = ~out_valid | out_ready;
  assign in_ready = en;

  pwam_dot u_dx (.clk, .en, .c(cfg.xc), .r(cfg.xr), .k(cfg.x0),
    .col(in_out_col), .row(in_out_row), .sum(xs));
  pwam_dot u_dy (.clk, .en, .c(cfg.yc), .r(cfg.yr), .k(cfg.y0),
    .col(in_out_col), .row(in_out_row), .sum(ys));
  pwam_dot u_dw (.clk, .en, .c(cfg.wc), .r(cfg.wr), .k(cfg.w0),
    .col(in_out_col), .row(in_out_row), .sum(ws));

  // magnitudes, quotient signs and the zero check on w
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= xs[AW-1] ? AW'(-xs) : xs;
      ay_r <= ys[AW-1] ? AW'(-ys) : ys;
      aw_r <= ws[AW-1] ? AW'(-ws) : ws;
      nx_r <= xs[AW-1] ^ ws[AW-1];
      ny_r <= ys[AW-1] ^ ws[AW-1];
      wz_r <= (ws == '0);
    end
  end

  pwam_div #(.NW(AW), .QB(QB)) u_divx (.clk, .en, .num(ax_r), .den(aw_r),
    .quo(qx), .ovf(ox));
  pwam_div #(.NW(AW), .QB(QB)) u_divy (.clk, .en, .num(ay_r), .den(aw_r),
    .quo(qy), .ovf(oy));

  always_ff @(posedge clk) begin
    if (en) begin
      nx_d <= {nx_d[QB-1:0], nx_r};
      ny_d <= {ny_d[QB-1:0], ny_r};
      wz_d <= {wz_d[QB-1:0], wz_r};
    end
  end

  always_comb begin
    ins = ~wz_d[QB] & ~ox & ~oy & (qx < cfg.wlim) & (qy < cfg.hlim)
        & ~(nx_d[QB] & (qx != '0)) & ~(ny_d[QB] & (qy != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_valid};
  end
  assign out_valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside_res <= ins;
      out_src_x <= ins ? qx[10:0] : '0;
      out_src_y <= ins ? qy[10:0] : '0;
    end
  end
endmodule
`default_nettype wire
